>>> hdl/laplacian_sharpen_3x3_macros.svh
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3 assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef LAPLACIAN_SHARPEN_3X3_MACROS_SVH
`define LAPLACIAN_SHARPEN_3X3_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define LSH_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// consequent checked in the cycle after the antecedent
`define LSH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LSH_ASSERT(lbl, clk, rstn, prop, msg)
`define LSH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> hdl/lsh_pkg.sv
// ----------------------------------------------------------------------------
// lsh_pkg
// Types and constants shared by the 3x3 Laplacian sharpening filter.
// ----------------------------------------------------------------------------
`default_nettype none

package lsh_pkg;

    localparam int MAX_WIDTH = 512;
    localparam int PIX_W     = 8;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = 10;
    localparam int HGT_W     = 12;
    localparam int ROW_W     = 12;
    localparam int INROW_W   = HGT_W + 1;
    localparam int LINE_W    = 2 * PIX_W;
    localparam int CFG_W     = 12;
    localparam int ACC_W     = 15;

    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(352);
    localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(288);

    localparam int CENTER_GAIN = 22;
    localparam int EDGE_GAIN   = 4;
    localparam int OUT_OFFSET  = 127;
    localparam int PIX_MAX     = 255;

    // register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // [row][col], row 0 is the top, col 0 the left
    typedef logic [2:0][2:0][PIX_W-1:0] lsh_win_t;

    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } lsh_mask_t;

    typedef struct packed {
        logic             emit;
        lsh_mask_t        mask;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             fe;
    } lsh_info_t;

    typedef struct packed {
        lsh_win_t         win;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             fe;
    } lsh_entry_t;

    typedef struct packed {
        logic              valid;
        lsh_entry_t        entry;
    } lsh_push_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } lsh_qstat_t;

endpackage

`default_nettype wire

>>> hdl/lsh_ram.sv
// ----------------------------------------------------------------------------
// lsh_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read-first: a same-address write is not seen until the next read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hdl/lsh_front.sv
// ----------------------------------------------------------------------------
// lsh_front
// Accepts words, tracks the raster position, classifies each word and
// builds the masked 3x3 neighbourhood from the line buffers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "laplacian_sharpen_3x3_macros.svh"

module lsh_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic                      cfg_index,
    input  wire logic [lsh_pkg::CFG_W-1:0] cfg_wdata,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [lsh_pkg::PIX_W-1:0] s_tdata,
    input  wire logic                      s_tuser,
    input  wire lsh_pkg::lsh_qstat_t       qstat,
    output lsh_pkg::lsh_push_t             push
);

    logic [lsh_pkg::WID_W-1:0]   width_reg;
    logic [lsh_pkg::HGT_W-1:0]   height_reg;
    logic [lsh_pkg::INROW_W-1:0] in_row_reg, in_row_next;
    logic [lsh_pkg::COL_W-1:0]   in_col_reg, in_col_next;
    lsh_pkg::lsh_win_t           window_reg, window_next;

    logic                        b_valid_reg;
    logic [lsh_pkg::PIX_W-1:0]   b_pix_reg;
    logic [lsh_pkg::COL_W-1:0]   b_addr_reg;
    lsh_pkg::lsh_info_t          b_info_reg, info_a;
    logic                        fwd_reg;
    logic [lsh_pkg::LINE_W-1:0]  fwd_data_reg;

    logic [lsh_pkg::WID_W-1:0]   w_eff, w_m1;
    logic [lsh_pkg::HGT_W-1:0]   h_eff;
    logic                        accept;
    logic                        col_zero;
    logic [lsh_pkg::INROW_W-1:0] orow_a;
    logic [lsh_pkg::COL_W-1:0]   ocol_a;
    logic [lsh_pkg::WID_W-1:0]   col_inc;
    logic [lsh_pkg::INROW_W-1:0] row_inc;
    logic [lsh_pkg::LINE_W-1:0]  rd_line, line_b, wr_line;
    logic [lsh_pkg::PIX_W-1:0]   up_b, mid_b;
    lsh_pkg::lsh_win_t           win_masked;

    // effective frame size
    always_comb begin
        if (width_reg == '0) begin
            w_eff = lsh_pkg::WID_W'(1);
        end else if (width_reg > lsh_pkg::WID_W'(lsh_pkg::MAX_WIDTH)) begin
            w_eff = lsh_pkg::WID_W'(lsh_pkg::MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        h_eff = (height_reg == '0) ? lsh_pkg::HGT_W'(1) : height_reg;
        w_m1  = w_eff - lsh_pkg::WID_W'(1);
    end

    // hold new words back in reset, during a register write and while the
    // queue could overflow
    assign s_tready = aresetn && !cfg_wr_en
                      && (((lsh_pkg::QCNT_W+1)'(qstat.count)
                           + (lsh_pkg::QCNT_W+1)'(b_valid_reg))
                          < (lsh_pkg::QCNT_W+1)'(lsh_pkg::QDEPTH));
    assign accept   = s_tvalid && s_tready;

    // classify the word at the current position
    always_comb begin
        col_zero    = (in_col_reg == '0);
        info_a.emit = (in_row_reg >= lsh_pkg::INROW_W'(2))
                   || ((in_row_reg == lsh_pkg::INROW_W'(1)) && !col_zero);
        if (col_zero) begin
            ocol_a = w_m1[lsh_pkg::COL_W-1:0];
            orow_a = in_row_reg - lsh_pkg::INROW_W'(2);
        end else begin
            ocol_a = in_col_reg - lsh_pkg::COL_W'(1);
            orow_a = in_row_reg - lsh_pkg::INROW_W'(1);
        end
        info_a.mask.top    = (orow_a == '0);
        info_a.mask.bottom = ((lsh_pkg::INROW_W+1)'(orow_a) + (lsh_pkg::INROW_W+1)'(1))
                             >= (lsh_pkg::INROW_W+1)'(h_eff);
        info_a.mask.left   = (ocol_a == '0);
        info_a.mask.right  = (lsh_pkg::WID_W'(ocol_a) + lsh_pkg::WID_W'(1)) >= w_eff;
        info_a.row         = orow_a[lsh_pkg::ROW_W-1:0];
        info_a.col         = ocol_a;
        info_a.fe          = (orow_a == (lsh_pkg::INROW_W'(h_eff) - lsh_pkg::INROW_W'(1)))
                          && (lsh_pkg::WID_W'(ocol_a) == w_m1);
    end

    // advance the raster position
    always_comb begin
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        col_inc     = lsh_pkg::WID_W'(in_col_reg) + lsh_pkg::WID_W'(1);
        row_inc     = in_row_reg + lsh_pkg::INROW_W'(1);
        if (accept) begin
            if (info_a.emit && info_a.fe) begin
                in_col_next = '0;
                in_row_next = '0;
            end else if (col_inc >= w_eff) begin
                in_col_next = '0;
                if (row_inc > (lsh_pkg::INROW_W'(h_eff) + lsh_pkg::INROW_W'(1))) begin
                    in_row_next = '0;
                end else begin
                    in_row_next = row_inc;
                end
            end else begin
                in_col_next = col_inc[lsh_pkg::COL_W-1:0];
            end
        end
    end

    // line buffer word: above row in the upper byte, current row in the lower
    lsh_ram #(
        .WIDTH (lsh_pkg::LINE_W),
        .DEPTH (lsh_pkg::MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (b_valid_reg),
        .wr_addr (b_addr_reg),
        .wr_data (wr_line),
        .rd_addr (in_col_reg),
        .rd_data (rd_line)
    );

    always_comb begin
        line_b  = fwd_reg ? fwd_data_reg : rd_line;
        up_b    = line_b[lsh_pkg::LINE_W-1:lsh_pkg::PIX_W];
        mid_b   = line_b[lsh_pkg::PIX_W-1:0];
        wr_line = {mid_b, b_pix_reg};
    end

    // shift the window left and take the new column on the right
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            window_next[r][0] = window_reg[r][1];
            window_next[r][1] = window_reg[r][2];
        end
        window_next[0][2] = up_b;
        window_next[1][2] = mid_b;
        window_next[2][2] = b_pix_reg;

        win_masked = window_next;
        for (int k = 0; k < 3; k++) begin
            if (b_info_reg.mask.top)    win_masked[0][k] = '0;
            if (b_info_reg.mask.bottom) win_masked[2][k] = '0;
            if (b_info_reg.mask.left)   win_masked[k][0] = '0;
            if (b_info_reg.mask.right)  win_masked[k][2] = '0;
        end

        push.valid     = b_valid_reg && b_info_reg.emit;
        push.entry.win = win_masked;
        push.entry.row = b_info_reg.row;
        push.entry.col = b_info_reg.col;
        push.entry.fe  = b_info_reg.fe;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= lsh_pkg::WIDTH_RESET;
            height_reg  <= lsh_pkg::HEIGHT_RESET;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            window_reg  <= '0;
            b_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lsh_pkg::REG_FRAME_WIDTH: begin
                    width_reg <= cfg_wdata[lsh_pkg::WID_W-1:0];
                end
                lsh_pkg::REG_FRAME_HEIGHT: begin
                    height_reg <= cfg_wdata[lsh_pkg::HGT_W-1:0];
                end
                default: begin
                end
            endcase
            // restart the frame
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            window_reg  <= '0;
            b_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end else begin
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            b_valid_reg <= accept;
            // the RAM returns stale data when this read meets the pending write
            fwd_reg     <= b_valid_reg && (b_addr_reg == in_col_reg);
            if (b_valid_reg) begin
                window_reg <= window_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= wr_line;
        if (accept) begin
            b_pix_reg  <= s_tuser ? '0 : s_tdata;
            b_addr_reg <= in_col_reg;
            b_info_reg <= info_a;
        end
    end

    `LSH_ASSERT(a_col_in_row, aclk, aresetn, lsh_pkg::WID_W'(in_col_reg) < w_eff, "column beyond frame width")
    `LSH_ASSERT_NEXT(a_fwd_hit, aclk, aresetn, !cfg_wr_en && accept && b_valid_reg && (b_addr_reg == in_col_reg), fwd_reg, "line buffer collision not forwarded")
    `LSH_ASSERT(a_row_bound, aclk, aresetn, in_row_reg <= (lsh_pkg::INROW_W'(h_eff) + lsh_pkg::INROW_W'(1)), "row beyond flush rows")

endmodule

`default_nettype wire

>>> hdl/lsh_queue.sv
// ----------------------------------------------------------------------------
// lsh_queue
// Short FIFO of neighbourhood entries between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "laplacian_sharpen_3x3_macros.svh"

module lsh_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire lsh_pkg::lsh_push_t push,
    input  wire logic               pop,
    output logic                    q_valid,
    output lsh_pkg::lsh_entry_t     q_data,
    output lsh_pkg::lsh_qstat_t     qstat
);

    lsh_pkg::lsh_entry_t         entries_reg [lsh_pkg::QDEPTH];
    logic [lsh_pkg::QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [lsh_pkg::QCNT_W-1:0]  count_reg, count_next;

    assign q_valid     = (count_reg != '0);
    assign q_data      = entries_reg[rd_ptr_reg];
    assign qstat.count = count_reg;

    always_comb begin
        count_next = count_reg;
        if (push.valid && !pop) begin
            count_next = count_reg + lsh_pkg::QCNT_W'(1);
        end else if (!push.valid && pop) begin
            count_next = count_reg - lsh_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push.valid) begin
                wr_ptr_reg <= wr_ptr_reg + lsh_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + lsh_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            entries_reg[wr_ptr_reg] <= push.entry;
        end
    end

    `LSH_ASSERT(a_no_overflow, aclk, aresetn, !push.valid || pop || (count_reg != lsh_pkg::QCNT_W'(lsh_pkg::QDEPTH)), "queue overflow")
    `LSH_ASSERT(a_no_underflow, aclk, aresetn, !pop || (count_reg != '0), "queue underflow")

endmodule

`default_nettype wire

>>> hdl/lsh_back.sv
// ----------------------------------------------------------------------------
// lsh_back
// Applies the sharpening kernel to the queue head, clamps, and drives the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_valid,
    input  wire lsh_pkg::lsh_entry_t q_data,
    output logic                     pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [31:0]              m_tdata,
    output logic                     m_tlast
);

    logic                             m_valid_reg;
    logic [lsh_pkg::PIX_W-1:0]        sharp_reg, sharp_next;
    logic [lsh_pkg::ROW_W-1:0]        row_reg;
    logic [lsh_pkg::COL_W-1:0]        col_reg;
    logic                             last_reg;

    logic [lsh_pkg::ACC_W-1:0]        pos_sum, neg_sum;
    logic [lsh_pkg::PIX_W+1:0]        edge_sum, corner_sum;
    logic signed [lsh_pkg::ACC_W-1:0] acc;

    assign pop = q_valid && (!m_valid_reg || m_tready);

    always_comb begin
        edge_sum   = (lsh_pkg::PIX_W+2)'(q_data.win[0][1]) + (lsh_pkg::PIX_W+2)'(q_data.win[2][1])
                   + (lsh_pkg::PIX_W+2)'(q_data.win[1][0]) + (lsh_pkg::PIX_W+2)'(q_data.win[1][2]);
        corner_sum = (lsh_pkg::PIX_W+2)'(q_data.win[0][0]) + (lsh_pkg::PIX_W+2)'(q_data.win[0][2])
                   + (lsh_pkg::PIX_W+2)'(q_data.win[2][0]) + (lsh_pkg::PIX_W+2)'(q_data.win[2][2]);
        pos_sum    = lsh_pkg::ACC_W'(q_data.win[1][1]) * lsh_pkg::ACC_W'(lsh_pkg::CENTER_GAIN)
                   + lsh_pkg::ACC_W'(lsh_pkg::OUT_OFFSET);
        neg_sum    = lsh_pkg::ACC_W'(edge_sum) * lsh_pkg::ACC_W'(lsh_pkg::EDGE_GAIN)
                   + lsh_pkg::ACC_W'(corner_sum);
        acc        = $signed(pos_sum - neg_sum);
        // clamp to byte range
        if (acc < 0) begin
            sharp_next = '0;
        end else if (acc > lsh_pkg::ACC_W'(lsh_pkg::PIX_MAX)) begin
            sharp_next = lsh_pkg::PIX_W'(lsh_pkg::PIX_MAX);
        end else begin
            sharp_next = acc[lsh_pkg::PIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            sharp_reg <= sharp_next;
            row_reg   <= q_data.row;
            col_reg   <= q_data.col;
            last_reg  <= q_data.fe;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, col_reg, row_reg, sharp_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

>>> hdl/laplacian_sharpen_3x3.sv
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3
// Streaming 3x3 Laplacian sharpening filter for 8-bit luma in raster order.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake        Contents
// s_        in   tvalid/tready    tdata: pixel[7:0]; tuser: mode (1 = flush)
// m_        out  tvalid/tready    tdata: sharp_pixel, out_row, out_col; tlast
// cfg_      in   cfg_wr_en only   index 0 frame_width, index 1 frame_height
//
// One word per clock sustained while m_tready stays high; each result passes
// through the input stage registers, a four-entry queue and the output
// register. The line buffer RAM is read on acceptance and written back the
// cycle after, with a bypass for back-to-back hits on one address.
// Reset is synchronous; line buffers are not cleared, out-of-frame rows
// are masked. s_tready is low in reset and during a register write, and
// drops once the queue and the word in flight fill it.
// ----------------------------------------------------------------------------
`default_nettype none

module laplacian_sharpen_3x3 (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic                      cfg_index,
    input  wire logic [lsh_pkg::CFG_W-1:0] cfg_wdata,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [7:0]                s_tdata,   // pixel[7:0]
    input  wire logic                      s_tuser,   // mode[0]
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [31:0]                    m_tdata,   // sharp_pixel[7:0], out_row[19:8],
                                                      // out_col[28:20], zero[31:29]
    output logic                           m_tlast    // frame_end
);

    lsh_pkg::lsh_push_t  push;
    lsh_pkg::lsh_qstat_t qstat;
    lsh_pkg::lsh_entry_t q_data;
    logic                q_valid;
    logic                pop;

    lsh_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .qstat     (qstat),
        .push      (push)
    );

    lsh_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .q_valid (q_valid),
        .q_data  (q_data),
        .qstat   (qstat)
    );

    lsh_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
